// ----- design/itt_pkg.sv -----
// shared types and constants for the idle timeout table
package itt_pkg;
  localparam int NumEntries = 16;
  localparam int SlotW      = $clog2(NumEntries);
  localparam int CntW       = $clog2(NumEntries + 1);
  localparam int TimeW      = 32;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [TimeW-1:0] time_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_REFRESH = 3'd1, OP_CANCEL = 3'd2, OP_TICK = 3'd3, OP_DESTROY = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0, ST_FULL = 3'd1, ST_DESTROYED = 3'd2, ST_EXPIRED = 3'd3,
    ST_DONE = 3'd4, ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_REAP = 2'd0, CFG_EXPIRY = 2'd1, CFG_NEVER = 2'd2, CFG_REPORT = 2'd3
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;       // capture input item
    logic  scan_step;  // advance search pointer
    logic  shift_step; // shift order list down by one at scan pointer
    logic  append;     // append slot at tail
    logic  remove_tail;
    logic  alloc;      // mark free slot live and stamp
    logic  restamp;
    logic  kill;       // clear live bit of target slot
    logic  tick;
    logic  sched_first;
    logic  sched_pass;
    logic  set_finished;
    logic  clr_ptr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  finished;
    logic  full;
    logic  empty;
    logic  target_live;
    logic  ptr_match;   // order[ptr] == target
    logic  ptr_at_end;  // ptr + 1 >= count
    logic  pass_due;
    logic  head_expired;
    slot_t free_slot;
    slot_t tail_slot;
    slot_t target;
    op_t   op;
  } sts_t;
endpackage

// ----- design/itt_datapath.sv -----
// datapath: entry store, order list, time and configuration registers
module itt_datapath import itt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_handle,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        report_on_destroy
);
  time_t stamp_r [NumEntries];
  slot_t order_r [NumEntries];
  logic [NumEntries-1:0] live_r;
  cnt_t  count_r;
  cnt_t  ptr_r;
  time_t now_r, next_r;
  logic  finished_r;
  logic [15:0] reap_r, expiry_r;
  logic  never_r, report_r;
  op_t   op_r;
  slot_t target_r;
  logic  target_ok_r;

  slot_t free_slot;
  logic  any_free;
  time_t age, delay;
  logic [TimeW:0] d_full;
  slot_t ptr_idx, last_idx;

  assign report_on_destroy = report_r;
  assign ptr_idx  = ptr_r[SlotW-1:0];
  assign last_idx = SlotW'(count_r - cnt_t'(1));

  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_slot = SlotW'(i);
        any_free  = 1'b1;
      end
    end
  end

  assign age = now_r - stamp_r[order_r[0]];
  assign d_full = {{(TimeW-15){1'b0}}, expiry_r} - {1'b0, age};
  always_comb begin
    if (d_full[TimeW:16] != '0 || d_full[15:0] < reap_r) delay = time_t'(reap_r);
    else delay = d_full[TimeW-1:0];
    if (delay == '0) delay = time_t'(1);
  end

  always_comb begin
    sts.finished     = finished_r;
    sts.full         = !any_free || count_r >= cnt_t'(NumEntries);
    sts.empty        = count_r == '0;
    sts.target_live  = target_ok_r && live_r[target_r];
    sts.ptr_match    = order_r[ptr_idx] == target_r;
    sts.ptr_at_end   = (ptr_r + cnt_t'(1)) >= count_r;
    sts.pass_due     = !finished_r && !never_r && count_r != '0 && now_r == next_r;
    sts.head_expired = age >= time_t'(expiry_r);
    sts.free_slot    = free_slot;
    sts.tail_slot    = order_r[last_idx];
    sts.target       = target_r;
    sts.op           = op_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0; count_r <= '0; now_r <= '0; next_r <= '0; finished_r <= 1'b0;
      reap_r <= 16'd1; expiry_r <= 16'd10; never_r <= 1'b0; report_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_REAP:   reap_r   <= cfg_data;
          CFG_EXPIRY: expiry_r <= cfg_data;
          CFG_NEVER:  never_r  <= cfg_data[0];
          CFG_REPORT: report_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        op_r        <= op_t'(in_opcode);
        target_r    <= SlotW'(in_handle);
        target_ok_r <= 32'(in_handle) < NumEntries;
      end
      if (cmd.clr_ptr) ptr_r <= '0;
      else if (cmd.scan_step || cmd.shift_step) ptr_r <= ptr_r + cnt_t'(1);
      if (cmd.shift_step && !sts.ptr_at_end) order_r[ptr_idx] <= order_r[ptr_idx + slot_t'(1)];
      if (cmd.tick) now_r <= now_r + time_t'(1);
      if (cmd.kill) begin
        live_r[target_r] <= 1'b0;
        count_r <= count_r - cnt_t'(1);
      end
      if (cmd.remove_tail) begin
        live_r[order_r[last_idx]] <= 1'b0;
        count_r <= count_r - cnt_t'(1);
      end
      if (cmd.alloc) begin
        live_r[free_slot]  <= 1'b1;
        stamp_r[free_slot] <= now_r;
        order_r[count_r[SlotW-1:0]] <= free_slot;
        count_r <= count_r + cnt_t'(1);
        target_r <= free_slot;
      end
      if (cmd.restamp) begin
        live_r[target_r]  <= 1'b1;
        stamp_r[target_r] <= now_r;
        order_r[last_idx] <= target_r;
      end
      if (cmd.sched_first) next_r <= now_r + time_t'(expiry_r == '0 ? 16'd1 : expiry_r);
      if (cmd.sched_pass)  next_r <= now_r + delay;
      if (cmd.set_finished) finished_r <= 1'b1;
      if (cmd.append) target_r <= order_r[0];
    end
  end
endmodule

// ----- design/itt_ctrl.sv -----
// controller state machine sequencing each operation
module itt_ctrl import itt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sts_t        sts,
  input  logic        report_on_destroy,
  output cmd_t        cmd,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_last
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FIND, S_SHIFT, S_PASS, S_DESTROY, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic [2:0] st_r, st_nxt;
  slot_t  sl_r, sl_nxt;
  logic   last_r, last_nxt;
  logic   refresh_r, refresh_nxt;
  logic   reaped_r, reaped_nxt;
  state_t ret_r, ret_nxt;

  assign in_ready   = state_r == S_IDLE;
  assign out_valid  = ov_r;
  assign out_status = st_r;
  assign out_slot   = 4'(sl_r);
  assign out_last   = last_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r; ov_nxt = ov_r; st_nxt = st_r; sl_nxt = sl_r;
    last_nxt = last_r; refresh_nxt = refresh_r; reaped_nxt = reaped_r; ret_nxt = ret_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_DECODE;
      end
      S_DECODE: begin
        ret_nxt = S_IDLE; last_nxt = 1'b1; state_nxt = S_OUT; ov_nxt = 1'b1;
        case (sts.op)
          OP_ADD: begin
            if (sts.finished) begin
              st_nxt = ST_DESTROYED; sl_nxt = '0;
            end else if (sts.full) begin
              st_nxt = ST_FULL; sl_nxt = '0;
            end else begin
              cmd.alloc = 1'b1; st_nxt = ST_ADDED; sl_nxt = sts.free_slot;
              if (sts.empty) cmd.sched_first = 1'b1;
            end
          end
          OP_REFRESH, OP_CANCEL: begin
            sl_nxt = sts.target;
            if (!sts.target_live) st_nxt = ST_IGNORED;
            else begin
              refresh_nxt = sts.op == OP_REFRESH;
              cmd.clr_ptr = 1'b1; ov_nxt = 1'b0; state_nxt = S_FIND;
            end
          end
          OP_TICK: begin
            cmd.tick = 1'b1; reaped_nxt = 1'b0; ov_nxt = 1'b0; state_nxt = S_PASS;
          end
          OP_DESTROY: begin
            st_nxt = ST_DONE; sl_nxt = '0;
            if (!sts.finished) begin
              cmd.set_finished = 1'b1;
              if (report_on_destroy && !sts.empty) begin
                // pointer at zero makes ptr_at_end flag the last remaining entry
                cmd.clr_ptr = 1'b1; ov_nxt = 1'b0; state_nxt = S_DESTROY;
              end
            end
          end
          default: begin
            st_nxt = ST_IGNORED; sl_nxt = '0;
          end
        endcase
      end
      S_FIND: begin
        if (sts.ptr_match) state_nxt = S_SHIFT;
        else cmd.scan_step = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.ptr_at_end) begin
          if (refresh_r) cmd.restamp = 1'b1;
          else cmd.kill = 1'b1;
          sl_nxt = sts.target;
          if (sts.op == OP_TICK) begin
            // reaped entry: hold the transfer until the next head is checked
            st_nxt = ST_EXPIRED; reaped_nxt = 1'b1; state_nxt = S_PASS;
          end else begin
            st_nxt = ST_DONE; last_nxt = 1'b1;
            ov_nxt = 1'b1; ret_nxt = S_IDLE; state_nxt = S_OUT;
          end
        end
      end
      S_PASS: begin
        if (reaped_r) begin
          // send the held expired transfer; it is last unless the new head goes too
          reaped_nxt = 1'b0; ov_nxt = 1'b1; last_nxt = 1'b1; ret_nxt = S_IDLE;
          state_nxt = S_OUT;
          if (sts.pass_due && sts.head_expired) begin
            last_nxt = 1'b0; ret_nxt = S_PASS;
          end else if (sts.pass_due) cmd.sched_pass = 1'b1;
        end else if (sts.pass_due && sts.head_expired) begin
          // pull the head out: reuse the cancel shift with the head as target
          cmd.append = 1'b1; cmd.clr_ptr = 1'b1; refresh_nxt = 1'b0; state_nxt = S_SHIFT;
        end else begin
          if (sts.pass_due) cmd.sched_pass = 1'b1;
          st_nxt = ST_DONE; sl_nxt = '0; last_nxt = 1'b1; ov_nxt = 1'b1;
          ret_nxt = S_IDLE; state_nxt = S_OUT;
        end
      end
      S_DESTROY: begin
        cmd.remove_tail = 1'b1; st_nxt = ST_EXPIRED; sl_nxt = sts.tail_slot;
        last_nxt = sts.ptr_at_end; ov_nxt = 1'b1; ret_nxt = S_DESTROY; state_nxt = S_OUT;
        if (sts.ptr_at_end) ret_nxt = S_IDLE;
      end
      S_OUT: if (out_ready) begin
        ov_nxt = 1'b0; state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; refresh_r <= 1'b0; reaped_r <= 1'b0; ret_r <= S_IDLE;
      last_r <= 1'b0; st_r <= '0; sl_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; refresh_r <= refresh_nxt;
      reaped_r <= reaped_nxt; ret_r <= ret_nxt;
      st_r <= st_nxt; sl_r <= sl_nxt; last_r <= last_nxt;
    end
  end
endmodule

// ----- design/idle_timeout_table_core.sv -----
// top level of the idle timeout table
// Idle timeout table: up to 16 live entries kept oldest-to-newest with a
// 32-bit stamp each, one item handled at a time. Add, a refused add,
// destroy without reporting and an unknown opcode go through accept, decode
// and result transfer; a tick with no reaping adds a head check before the
// transfer; refresh and cancel walk the order list one position per cycle to
// find the handle and close the gap; a tick that runs a pass handles each
// reaped entry in turn (head check, shift out, next head check, transfer);
// destroy with reporting removes and transfers each remaining entry from the
// tail. Each result transfer waits for out_ready; the block takes a new item
// only once the previous one is done.
module idle_timeout_table_core import itt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic report;

  // config is always taken; writes must happen while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  itt_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_handle,
    .cfg_we(cfg_valid), .cfg_index, .cfg_data, .report_on_destroy(report)
  );

  itt_ctrl u_ctrl (
    .clk, .rst_n, .sts, .report_on_destroy(report), .cmd,
    .in_valid, .in_ready, .out_valid, .out_ready, .out_status, .out_slot, .out_last
  );
endmodule

// ----- design/itt_checker.sv -----
// port-level checks for the idle timeout table
module itt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted twice");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("result while idle");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd5) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind idle_timeout_table_core itt_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_status
);

// ----- verif/idle_timeout_table_checker.sv -----
// checker for the idle timeout table: watches the channels, predicts and compares
module idle_timeout_table_checker import itt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_handle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_slot,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    status_t st;
    slot_t   slot;
    logic    last;
  } verdict_t;

  verdict_t awaited_q[$];

  // shadow table
  time_t stamp [NumEntries];
  logic  live  [NumEntries];
  slot_t order [NumEntries];
  int    live_cnt;
  time_t now_t;
  time_t pass_at;
  logic  destroyed;

  logic [15:0] reap_iv;
  logic [15:0] expiry_iv;
  logic        no_reap;
  logic        report_all;

  assign pending = awaited_q.size();

  task automatic await_result(input status_t st, input slot_t slot);
    verdict_t v;
    v.st = st;
    v.slot = slot;
    v.last = 1'b0;
    awaited_q.insert(awaited_q.size(), v);
  endtask

  task automatic drop_at(input int pos);
    live[order[pos]] = 1'b0;
    for (int i = pos; i + 1 < live_cnt; i++) order[i] = order[i + 1];
    live_cnt--;
  endtask

  task automatic schedule_pass(input time_t delay);
    if (delay == '0) delay = 1;
    pass_at = now_t + delay;
  endtask

  task automatic apply_item(input logic [2:0] op, input logic [3:0] h);
    int       before_n;
    int       pos;
    int       free_i;
    slot_t    s;
    time_t    age;
    time_t    d;
    before_n = awaited_q.size();
    pos = -1;
    free_i = -1;
    case (op)
      OP_ADD: begin
        for (int i = NumEntries - 1; i >= 0; i--) if (!live[i]) free_i = i;
        if (destroyed) await_result(ST_DESTROYED, '0);
        else if (free_i < 0 || live_cnt >= NumEntries) await_result(ST_FULL, '0);
        else begin
          live[free_i] = 1'b1;
          stamp[free_i] = now_t;
          order[live_cnt] = slot_t'(free_i);
          live_cnt++;
          if (live_cnt == 1) schedule_pass(time_t'(expiry_iv));
          await_result(ST_ADDED, slot_t'(free_i));
        end
      end
      OP_REFRESH, OP_CANCEL: begin
        for (int i = 0; i < live_cnt; i++) if (order[i] == h && pos < 0) pos = i;
        if (!live[h] || pos < 0) await_result(ST_IGNORED, h);
        else begin
          drop_at(pos);
          if (op == OP_REFRESH) begin
            live[h] = 1'b1;
            stamp[h] = now_t;
            order[live_cnt] = h;
            live_cnt++;
          end
          await_result(ST_DONE, h);
        end
      end
      OP_TICK: begin
        now_t = now_t + 1;
        if (!destroyed && !no_reap && live_cnt > 0 && now_t == pass_at) begin
          age = '0;
          while (live_cnt > 0) begin
            s = order[0];
            age = now_t - stamp[s];
            if (age < time_t'(expiry_iv)) break;
            drop_at(0);
            await_result(ST_EXPIRED, s);
          end
          if (live_cnt > 0) begin
            d = time_t'(expiry_iv) - age;
            if (d < time_t'(reap_iv)) d = time_t'(reap_iv);
            schedule_pass(d);
          end
        end
        if (awaited_q.size() == before_n) await_result(ST_DONE, '0);
      end
      OP_DESTROY: begin
        if (!destroyed) begin
          destroyed = 1'b1;
          if (report_all) begin
            // newest first
            while (live_cnt > 0) begin
              s = order[live_cnt - 1];
              drop_at(live_cnt - 1);
              await_result(ST_EXPIRED, s);
            end
          end
        end
        if (awaited_q.size() == before_n) await_result(ST_DONE, '0);
      end
      default: await_result(ST_IGNORED, '0);
    endcase
    awaited_q[awaited_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      awaited_q.delete();
      for (int i = 0; i < NumEntries; i++) live[i] = 1'b0;
      live_cnt = 0;
      now_t = '0;
      pass_at = '0;
      destroyed = 1'b0;
      reap_iv = 16'd1;
      expiry_iv = 16'd10;
      no_reap = 1'b0;
      report_all = 1'b0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REAP:   reap_iv = cfg_data;
          CFG_EXPIRY: expiry_iv = cfg_data;
          CFG_NEVER:  no_reap = cfg_data[0];
          CFG_REPORT: report_all = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) apply_item(in_opcode, in_handle);
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing awaited: status %0d slot %0d last %0d",
                   $time, out_status, out_slot, out_last);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (out_status !== want.st || out_slot !== want.slot || out_last !== want.last) begin
            $display("%0t: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                     $time, want.st, want.slot, want.last, out_status, out_slot, out_last);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ----- verif/idle_timeout_table_core_tb.sv -----
// testbench top for the idle timeout table: stimulus, handshake idling and verdict
module idle_timeout_table_core_tb;
  import itt_pkg::*;

  localparam int          CycleLimit = 1500000;
  localparam int          DrainCycles = 80;   // settle time after the last awaited result
  localparam logic [2:0]  OpReserved = 3'd5;  // first of the unused opcodes

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [3:0]  in_handle;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int cycles;
  bit hold_off_req;  // asks the receiver for one long stall

  idle_timeout_table_core dut (.*);

  idle_timeout_table_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_handle,
    .out_valid, .out_ready, .out_status, .out_slot, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stalls, stretches of full speed, one long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        // the block holds its result while the sender keeps offering the next item
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      if (gap_len() > 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] reap, input logic [15:0] expiry,
                            input logic never, input logic report);
    write_reg(CFG_REAP, reap);
    write_reg(CFG_EXPIRY, expiry);
    write_reg(CFG_NEVER, {15'd0, never});
    write_reg(CFG_REPORT, {15'd0, report});
  endtask

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(input logic [2:0] op, input logic [3:0] h);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_handle <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering, wait for every awaited result, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(input int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return OP_ADD;
    if (r < add_pct + 15) return OP_REFRESH;
    if (r < add_pct + 27) return OP_CANCEL;
    if (r < 97) return OP_TICK;
    return OpReserved + 3'($urandom_range(0, 2));
  endfunction

  task automatic random_items(input int count, input int add_pct, input int hold_at,
                              input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_item(pick_op(add_pct), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_handle = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short expiry so passes happen quickly
    set_config(16'd1, 16'd3, 1'b0, 1'b0);
    send_item(OP_ADD, 4'd0);
    send_item(OP_ADD, 4'd15);
    send_item(OP_ADD, 4'd7);
    send_item(OP_REFRESH, 4'd1);
    send_item(OP_CANCEL, 4'd0);
    send_item(OP_CANCEL, 4'd0);       // no longer live
    send_item(OP_REFRESH, 4'd15);     // never allocated
    send_item(OP_TICK, 4'd0);
    send_item(OP_TICK, 4'd0);
    send_item(OP_TICK, 4'd0);         // pass due, oldest entries go
    send_item(OP_TICK, 4'd0);
    send_item(OpReserved, 4'd15);
    send_item(OpReserved + 3'd1, 4'd10);
    send_item(OpReserved + 3'd2, 4'd5);
    send_item(OP_ADD, 4'd0);
    send_item(OP_ADD, 4'd0);
    send_item(OP_TICK, 4'd0);
    send_item(OP_CANCEL, 4'd8);
    send_item(OP_TICK, 4'd0);
    send_item(OP_TICK, 4'd0);
    send_item(OP_TICK, 4'd0);
    quiesce();

    // moderate intervals, long receiver hold-off part way through
    set_config(16'd2, 16'd5, 1'b0, 1'b0);
    random_items(90, 35, 30, -1);
    quiesce();

    // largest intervals with reaping off: the table fills up
    set_config(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    random_items(60, 55, -1, -1);
    quiesce();

    // smallest intervals, one sender pause until everything has come back
    set_config(16'd1, 16'd1, 1'b0, 1'b0);
    random_items(50, 40, -1, 25);
    quiesce();

    // reap interval above expiry
    set_config(16'd40000, 16'd4, 1'b0, 1'b0);
    random_items(40, 40, -1, -1);
    quiesce();

    // destroy with reporting, then everything after it
    write_reg(CFG_REPORT, 16'd1);
    send_item(OP_ADD, 4'd0);
    send_item(OP_DESTROY, 4'd0);
    send_item(OP_DESTROY, 4'd9);      // repeated destroy
    send_item(OP_ADD, 4'd0);
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 4) == 0) send_item(OP_DESTROY, 4'($urandom_range(0, 15)));
      else send_item(pick_op(30), 4'($urandom_range(0, 15)));
    end
    quiesce();

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- idle_timeout_table_core.f -----
design/itt_pkg.sv
design/itt_datapath.sv
design/itt_ctrl.sv
design/idle_timeout_table_core.sv
design/itt_checker.sv
verif/idle_timeout_table_checker.sv
verif/idle_timeout_table_core_tb.sv
